// ===== hdl/segment_intersection_test_defines.svh =====
// Assertion macros shared by the segment intersection test RTL.
// No dependencies; included by modules that carry assertions.
`ifndef SEGMENT_INTERSECTION_TEST_DEFINES_SVH
`define SEGMENT_INTERSECTION_TEST_DEFINES_SVH

// Clocked property, checked only out of reset.
`define SIT_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Clocked property, checked during reset as well.
`define SIT_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ===== hdl/seg_pkg.sv =====
// Package for the segment intersection test: default coordinate width and
// the status flags that travel down the pipeline. No dependencies.
package seg_pkg;

    localparam int COORD_BITS_DEF = 16;

    typedef struct packed {
        logic degen;
        logic shared;
    } t_flags;

endpackage

// ===== hdl/seg_diff.sv =====
// Stage 1: endpoint differences relative to A and endpoint equality flags.
// Depends on seg_pkg.
module seg_diff #(
    parameter int COORD_BITS = seg_pkg::COORD_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  logic signed [COORD_BITS-1:0]  i_ax,
    input  logic signed [COORD_BITS-1:0]  i_ay,
    input  logic signed [COORD_BITS-1:0]  i_bx,
    input  logic signed [COORD_BITS-1:0]  i_by,
    input  logic signed [COORD_BITS-1:0]  i_cx,
    input  logic signed [COORD_BITS-1:0]  i_cy,
    input  logic signed [COORD_BITS-1:0]  i_dx,
    input  logic signed [COORD_BITS-1:0]  i_dy,
    output logic                          o_valid,
    output seg_pkg::t_flags               o_flags,
    output logic signed [COORD_BITS:0]    o_ux,
    output logic signed [COORD_BITS:0]    o_uy,
    output logic signed [COORD_BITS:0]    o_px,
    output logic signed [COORD_BITS:0]    o_py,
    output logic signed [COORD_BITS:0]    o_qx,
    output logic signed [COORD_BITS:0]    o_qy
);
    import seg_pkg::*;

    localparam int DW = COORD_BITS + 1;

    logic                 r_valid;
    t_flags               r_flags, n_flags;
    logic signed [DW-1:0] r_ux, r_uy, r_px, r_py, r_qx, r_qy;
    logic signed [DW-1:0] n_ux, n_uy, n_px, n_py, n_qx, n_qy;
    logic                 ab_eq, cd_eq, ac_eq, bc_eq, ad_eq, bd_eq;

    always_comb begin
        ab_eq = (i_ax == i_bx) && (i_ay == i_by);
        cd_eq = (i_cx == i_dx) && (i_cy == i_dy);
        ac_eq = (i_ax == i_cx) && (i_ay == i_cy);
        bc_eq = (i_bx == i_cx) && (i_by == i_cy);
        ad_eq = (i_ax == i_dx) && (i_ay == i_dy);
        bd_eq = (i_bx == i_dx) && (i_by == i_dy);
        n_flags.degen  = ab_eq || cd_eq;
        n_flags.shared = ac_eq || bc_eq || ad_eq || bd_eq;
        n_ux = {i_bx[COORD_BITS-1], i_bx} - {i_ax[COORD_BITS-1], i_ax};
        n_uy = {i_by[COORD_BITS-1], i_by} - {i_ay[COORD_BITS-1], i_ay};
        n_px = {i_cx[COORD_BITS-1], i_cx} - {i_ax[COORD_BITS-1], i_ax};
        n_py = {i_cy[COORD_BITS-1], i_cy} - {i_ay[COORD_BITS-1], i_ay};
        n_qx = {i_dx[COORD_BITS-1], i_dx} - {i_ax[COORD_BITS-1], i_ax};
        n_qy = {i_dy[COORD_BITS-1], i_dy} - {i_ay[COORD_BITS-1], i_ay};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_flags <= n_flags;
        r_ux    <= n_ux;
        r_uy    <= n_uy;
        r_px    <= n_px;
        r_py    <= n_py;
        r_qx    <= n_qx;
        r_qy    <= n_qy;
    end

    assign o_valid = r_valid;
    assign o_flags = r_flags;
    assign o_ux    = r_ux;
    assign o_uy    = r_uy;
    assign o_px    = r_px;
    assign o_py    = r_py;
    assign o_qx    = r_qx;
    assign o_qy    = r_qy;

endmodule

// ===== hdl/seg_cross.sv =====
// Stages 2 and 3: six registered products, then the three cross products
// (ordinates of C and D, and the crossing numerator). Depends on seg_pkg.
module seg_cross #(
    parameter int COORD_BITS = seg_pkg::COORD_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    input  seg_pkg::t_flags                 i_flags,
    input  logic signed [COORD_BITS:0]      i_ux,
    input  logic signed [COORD_BITS:0]      i_uy,
    input  logic signed [COORD_BITS:0]      i_px,
    input  logic signed [COORD_BITS:0]      i_py,
    input  logic signed [COORD_BITS:0]      i_qx,
    input  logic signed [COORD_BITS:0]      i_qy,
    output logic                            o_valid,
    output seg_pkg::t_flags                 o_flags,
    output logic signed [2*COORD_BITS+2:0]  o_ordc,
    output logic signed [2*COORD_BITS+2:0]  o_ordd,
    output logic signed [2*COORD_BITS+2:0]  o_num
);
    import seg_pkg::*;

    localparam int PW = 2 * COORD_BITS + 2;
    localparam int CW = PW + 1;

    logic                 r_v2, r_v3;
    t_flags               r_f2, r_f3;
    logic signed [PW-1:0] r_ux_py, r_uy_px, r_ux_qy, r_uy_qx, r_px_qy, r_py_qx;
    logic signed [CW-1:0] r_ordc, r_ordd, r_num;
    logic signed [CW-1:0] n_ordc, n_ordd, n_num;

    always_comb begin
        n_ordc = {r_ux_py[PW-1], r_ux_py} - {r_uy_px[PW-1], r_uy_px};
        n_ordd = {r_ux_qy[PW-1], r_ux_qy} - {r_uy_qx[PW-1], r_uy_qx};
        n_num  = {r_px_qy[PW-1], r_px_qy} - {r_py_qx[PW-1], r_py_qx};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v2 <= i_valid;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        r_f2    <= i_flags;
        r_ux_py <= i_ux * i_py;
        r_uy_px <= i_uy * i_px;
        r_ux_qy <= i_ux * i_qy;
        r_uy_qx <= i_uy * i_qx;
        r_px_qy <= i_px * i_qy;
        r_py_qx <= i_py * i_qx;
        r_f3    <= r_f2;
        r_ordc  <= n_ordc;
        r_ordd  <= n_ordd;
        r_num   <= n_num;
    end

    assign o_valid = r_v3;
    assign o_flags = r_f3;
    assign o_ordc  = r_ordc;
    assign o_ordd  = r_ordd;
    assign o_num   = r_num;

endmodule

// ===== hdl/seg_decide.sv =====
// Stages 4 and 5: crossing denominator, then the sign-aware range test and
// the final decision register. Depends on seg_pkg and the assertion macros.
`include "segment_intersection_test_defines.svh"

module seg_decide #(
    parameter int COORD_BITS = seg_pkg::COORD_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    input  seg_pkg::t_flags                 i_flags,
    input  logic signed [2*COORD_BITS+2:0]  i_ordc,
    input  logic signed [2*COORD_BITS+2:0]  i_ordd,
    input  logic signed [2*COORD_BITS+2:0]  i_num,
    output logic                            o_valid,
    output logic                            o_hit
);
    import seg_pkg::*;

    localparam int CW = 2 * COORD_BITS + 3;
    localparam int DENW = CW + 1;

    logic                   r_v4, r_v5;
    t_flags                 r_f4;
    logic signed [DENW-1:0] r_den, n_den;
    logic signed [DENW-1:0] r_num;
    logic                   r_opp, r_dpos;
    logic                   r_hit, n_hit;
    logic                   in_range;

    always_comb begin
        n_den = {i_ordd[CW-1], i_ordd} - {i_ordc[CW-1], i_ordc};
    end

    // den > 0: need 0 <= num <= den; den < 0: need den <= num <= 0
    always_comb begin
        if (r_dpos) begin
            in_range = !r_num[DENW-1] && (r_num <= r_den);
        end else begin
            in_range = (r_num[DENW-1] || (r_num == '0)) && (r_num >= r_den);
        end
        priority if (r_f4.degen) begin
            n_hit = 1'b0;
        end else if (r_f4.shared) begin
            n_hit = 1'b1;
        end else if (!r_opp) begin
            n_hit = 1'b0;
        end else begin
            n_hit = in_range;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v4  <= 1'b0;
            r_v5  <= 1'b0;
            r_hit <= 1'b0;
        end else begin
            r_v4  <= i_valid;
            r_v5  <= r_v4;
            r_hit <= r_v4 && n_hit;
        end
    end

    always_ff @(posedge i_clk) begin
        r_f4   <= i_flags;
        r_den  <= n_den;
        r_num  <= {i_num[CW-1], i_num};
        r_opp  <= i_ordc[CW-1] != i_ordd[CW-1];
        r_dpos <= i_ordc[CW-1];
    end

    assign o_valid = r_v5;
    assign o_hit   = r_hit;

    `SIT_ASSERT(a_den_nonzero, (r_v4 && r_opp) |-> (r_den != '0), "zero denominator on split sides")
    `SIT_ASSERT(a_den_sign, (r_v4 && r_opp) |-> (r_den[DENW-1] == !r_dpos), "denominator sign mismatch")

endmodule

// ===== hdl/segment_intersection_test.sv =====
// Top level of the segment intersection test: five-stage pipeline.
// Depends on seg_pkg, seg_diff, seg_cross, seg_decide and the assertion macros.
//
// One segment pair is taken every cycle that start is high (busy is always
// low); the answer appears on o_intersects with o_done high for one cycle,
// in the same order as the pairs were taken. Each pair passes through the
// pipeline in turn: differences, products, cross products, denominator,
// range test. The receiver cannot stall, so there is no back-pressure.
`include "segment_intersection_test_defines.svh"

module segment_intersection_test #(
    parameter int COORD_BITS = seg_pkg::COORD_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic signed [COORD_BITS-1:0]  i_first_start_x,
    input  logic signed [COORD_BITS-1:0]  i_first_start_y,
    input  logic signed [COORD_BITS-1:0]  i_first_end_x,
    input  logic signed [COORD_BITS-1:0]  i_first_end_y,
    input  logic signed [COORD_BITS-1:0]  i_second_start_x,
    input  logic signed [COORD_BITS-1:0]  i_second_start_y,
    input  logic signed [COORD_BITS-1:0]  i_second_end_x,
    input  logic signed [COORD_BITS-1:0]  i_second_end_y,
    output logic                          o_done,
    output logic                          o_intersects
);
    import seg_pkg::*;

    localparam int CW = 2 * COORD_BITS + 3;

    logic                   s1_valid, s3_valid;
    t_flags                 s1_flags, s3_flags;
    logic signed [COORD_BITS:0] s1_ux, s1_uy, s1_px, s1_py, s1_qx, s1_qy;
    logic signed [CW-1:0]   s3_ordc, s3_ordd, s3_num;

    assign busy = 1'b0;

    seg_diff #(
        .COORD_BITS (COORD_BITS)
    ) u_diff (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (start && !busy),
        .i_ax    (i_first_start_x),
        .i_ay    (i_first_start_y),
        .i_bx    (i_first_end_x),
        .i_by    (i_first_end_y),
        .i_cx    (i_second_start_x),
        .i_cy    (i_second_start_y),
        .i_dx    (i_second_end_x),
        .i_dy    (i_second_end_y),
        .o_valid (s1_valid),
        .o_flags (s1_flags),
        .o_ux    (s1_ux),
        .o_uy    (s1_uy),
        .o_px    (s1_px),
        .o_py    (s1_py),
        .o_qx    (s1_qx),
        .o_qy    (s1_qy)
    );

    seg_cross #(
        .COORD_BITS (COORD_BITS)
    ) u_cross (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s1_valid),
        .i_flags (s1_flags),
        .i_ux    (s1_ux),
        .i_uy    (s1_uy),
        .i_px    (s1_px),
        .i_py    (s1_py),
        .i_qx    (s1_qx),
        .i_qy    (s1_qy),
        .o_valid (s3_valid),
        .o_flags (s3_flags),
        .o_ordc  (s3_ordc),
        .o_ordd  (s3_ordd),
        .o_num   (s3_num)
    );

    seg_decide #(
        .COORD_BITS (COORD_BITS)
    ) u_decide (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s3_valid),
        .i_flags (s3_flags),
        .i_ordc  (s3_ordc),
        .i_ordd  (s3_ordd),
        .i_num   (s3_num),
        .o_valid (o_done),
        .o_hit   (o_intersects)
    );

    `SIT_ASSERT(a_latency, start |-> ##5 o_done, "accepted beat produced no result")
    `SIT_ASSERT(a_no_spurious, o_done |-> $past(start, 5), "result without accepted beat")
    `SIT_ASSERT_ALWAYS(a_quiet, !o_done |-> !o_intersects, "intersects high without done")

endmodule
